// File: design/mwrd_pkg.sv
// Shared constants for the Microwire EEPROM word-read master.
package mwrd_pkg;

    // EEPROM geometry
    localparam int ADDR_BITS = 6;
    localparam int DATA_BITS = 16;

    // Start bit plus read opcode, sent ahead of the address
    localparam int OPC_BITS = 3;
    localparam logic [OPC_BITS-1:0] READ_OPCODE = 3'b110;
    localparam int CMD_BITS = OPC_BITS + ADDR_BITS;

    // Bit counter covers the longer of the command and the data word
    localparam int IDX_DEPTH = (CMD_BITS > DATA_BITS) ? CMD_BITS : DATA_BITS;
    localparam int IDX_W = $clog2(IDX_DEPTH);
    localparam logic [IDX_W-1:0] CMD_LAST_IDX = IDX_W'(CMD_BITS - 1);
    localparam logic [IDX_W-1:0] DATA_LAST_IDX = IDX_W'(DATA_BITS - 1);

    // Half-period register
    localparam int HOLD_W = 16;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd50;

endpackage

// File: design/microwire_eeprom_read_master.sv
// Microwire EEPROM word-read master: pin sequencer with registered tick results.
// Results: one per accepted tick, registered in the output register, or in the skid entry while the output stalls.
// Throughput: one tick per clock while o_in_stall is low; the sequencer step is a single compare and update.
// A two-entry result buffer (output register plus skid) keeps input stall registered.
// Reset (synchronous, active low): sequencer idle, counters and shifts cleared,
// half period set to 50, result buffer empty.
module microwire_eeprom_read_master
    import mwrd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // configuration write
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [HOLD_W-1:0]    i_cfg_half_period_ticks,

    // tick input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_start_req,
    input  logic [ADDR_BITS-1:0] i_word_addr,
    input  logic                 i_eeprom_do,

    // tick result
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_pin_access,
    output logic                 o_chip_select,
    output logic                 o_serial_clock,
    output logic                 o_data_to_eeprom,
    output logic                 o_done_res,
    output logic [DATA_BITS-1:0] o_read_data
);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_PROG    = 4'd1,
        PH_CS      = 4'd2,
        PH_CMD_LO  = 4'd3,
        PH_CMD_HI  = 4'd4,
        PH_TAIL_LO = 4'd5,
        PH_RX_HI   = 4'd6,
        PH_RX_LO   = 4'd7,
        PH_DONE    = 4'd8
    } t_phase;

    typedef struct packed {
        logic                 pin_access;
        logic                 chip_select;
        logic                 serial_clock;
        logic                 data_to_eeprom;
        logic                 done_res;
        logic [DATA_BITS-1:0] read_data;
    } t_result;

    // sequencer state
    logic [HOLD_W-1:0]    r_half;
    t_phase               r_phase,  n_phase;
    logic [HOLD_W-1:0]    r_delay,  n_delay;
    logic [IDX_W-1:0]     r_bit,    n_bit;
    logic [CMD_BITS-1:0]  r_cmd,    n_cmd;
    logic [DATA_BITS-1:0] r_rx,     n_rx;
    logic                 n_done;
    logic [HOLD_W-1:0]    hold;
    t_result              n_res;

    // result buffer
    logic                 r_out_valid;
    t_result              r_out;
    logic                 r_skid_valid;
    t_result              r_skid;

    logic                 in_xfer;
    logic                 out_xfer;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_xfer     = i_in_valid & ~r_skid_valid;
    assign out_xfer    = r_out_valid & ~i_out_stall;

    // Zero half period behaves as one tick
    assign hold = (r_half == '0) ? HOLD_W'(1) : r_half;

    // Sequencer step for one tick
    always_comb begin
        n_phase = r_phase;
        n_delay = r_delay;
        n_bit   = r_bit;
        n_cmd   = r_cmd;
        n_rx    = r_rx;
        n_done  = 1'b0;
        if (r_phase == PH_IDLE) begin
            if (i_start_req) begin
                n_cmd   = {READ_OPCODE, i_word_addr};
                n_rx    = '0;
                n_bit   = '0;
                n_phase = PH_PROG;
                n_delay = HOLD_W'(1);
            end
        end else if (r_delay < hold) begin
            n_delay = r_delay + HOLD_W'(1);
        end else begin
            n_delay = HOLD_W'(1);
            case (r_phase)
                PH_PROG: begin
                    n_phase = PH_CS;
                end
                PH_CS: begin
                    n_bit   = CMD_LAST_IDX;
                    n_phase = PH_CMD_LO;
                end
                PH_CMD_LO: begin
                    n_phase = PH_CMD_HI;
                end
                PH_CMD_HI: begin
                    if (r_bit == '0) begin
                        n_phase = PH_TAIL_LO;
                    end else begin
                        n_bit   = r_bit - IDX_W'(1);
                        n_phase = PH_CMD_LO;
                    end
                end
                PH_TAIL_LO: begin
                    n_bit   = DATA_LAST_IDX;
                    n_phase = PH_RX_HI;
                end
                PH_RX_HI: begin
                    // sample at the end of the clock-high hold
                    n_rx    = {r_rx[DATA_BITS-2:0], i_eeprom_do};
                    n_phase = PH_RX_LO;
                end
                PH_RX_LO: begin
                    if (r_bit == '0) begin
                        n_done  = 1'b1;
                        n_phase = PH_DONE;
                    end else begin
                        n_bit   = r_bit - IDX_W'(1);
                        n_phase = PH_RX_HI;
                    end
                end
                default: begin
                    // release phase over, or an unknown code
                    n_phase = PH_IDLE;
                    n_delay = '0;
                end
            endcase
        end
    end

    // Pin levels follow the new phase
    always_comb begin
        n_res.pin_access     = n_phase inside {[PH_PROG:PH_RX_LO]};
        n_res.chip_select    = n_phase inside {[PH_CS:PH_RX_LO]};
        n_res.serial_clock   = n_phase inside {PH_CMD_HI, PH_RX_HI};
        n_res.data_to_eeprom = 1'b0;
        if ((n_phase inside {PH_CMD_LO, PH_CMD_HI}) && (n_bit <= CMD_LAST_IDX)) begin
            n_res.data_to_eeprom = n_cmd[n_bit];
        end
        n_res.done_res  = n_done;
        n_res.read_data = n_done ? n_rx : '0;
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HOLD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_half <= i_cfg_half_period_ticks;
        end
    end

    // Sequencer state advances on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_delay <= '0;
            r_bit   <= '0;
            r_cmd   <= '0;
            r_rx    <= '0;
        end else if (in_xfer) begin
            r_phase <= n_phase;
            r_delay <= n_delay;
            r_bit   <= n_bit;
            r_cmd   <= n_cmd;
            r_rx    <= n_rx;
        end
    end

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_xfer) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (in_xfer) begin
            if (!r_out_valid || out_xfer) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_xfer) begin
                r_out <= r_skid;
            end
        end else if (in_xfer) begin
            if (!r_out_valid || out_xfer) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_pin_access     = r_out.pin_access;
    assign o_chip_select    = r_out.chip_select;
    assign o_serial_clock   = r_out.serial_clock;
    assign o_data_to_eeprom = r_out.data_to_eeprom;
    assign o_done_res       = r_out.done_res;
    assign o_read_data      = r_out.read_data;

endmodule
